// ===== sv/smsb_pkg.sv =====
// Package for the SPI master start-bit shifter: register codes, pin group type,
// step phase codes and sizing constants. No dependencies.
package smsb_pkg;

   // default and widths
   localparam int MAX_WORD_BITS_DEF = 32;
   localparam int QUEUE_DEPTH       = 2;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 32;
   localparam int WORD_W            = 32;
   localparam int CFG_BITS_W        = 6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_BITS     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_MASK     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_SELECTED = 2'd2;

   // register reset values
   localparam logic [CFG_BITS_W-1:0] WORD_BITS_RESET = 6'd8;
   localparam logic [WORD_W-1:0]     DATA_MASK_RESET = 32'hFFFF_FFFF;

   // item operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // step phase codes
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_SELECT   = 3'd1;
   localparam logic [2:0] PH_SB_DATA  = 3'd2;
   localparam logic [2:0] PH_SB_CLKH  = 3'd3;
   localparam logic [2:0] PH_SB_CLKL  = 3'd4;
   localparam logic [2:0] PH_BIT_DATA = 3'd5;
   localparam logic [2:0] PH_BIT_CLKH = 3'd6;
   localparam logic [2:0] PH_BIT_CLKL = 3'd7;

   // serial pin levels
   typedef struct packed {
      logic cs;
      logic clk;
      logic dout;
   } pins_type;

   // queue status between queue and its neighbors
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

// ===== sv/smsb_front.sv =====
// Front part: configuration registers, item acceptance, word masking and word
// size clamping. Depends on smsb_pkg.
module smsb_front #(
   parameter int MAX_WORD_BITS = 32,
   parameter int ENTRY_W       = 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic [smsb_pkg::WORD_W-1:0]      req_tx_word,
   input  logic                             req_din_level,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [smsb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [smsb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  smsb_pkg::queue_status_type       q_status,
   output logic                             q_push,
   output logic [ENTRY_W-1:0]               q_entry,
   output logic                             keep_selected
);
   import smsb_pkg::*;

   localparam int BL_W = $clog2(MAX_WORD_BITS + 1);

   logic [CFG_BITS_W-1:0] word_bits_ff;
   logic [WORD_W-1:0]     data_mask_ff;
   logic                  keep_sel_ff;
   logic [BL_W-1:0]       bits_clamped;
   logic [WORD_W-1:0]     masked_word;

   // take register writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_bits_ff <= WORD_BITS_RESET;
         data_mask_ff <= DATA_MASK_RESET;
         keep_sel_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WORD_BITS:     word_bits_ff <= csr_data[CFG_BITS_W-1:0];
            CSR_DATA_MASK:     data_mask_ff <= csr_data[WORD_W-1:0];
            CSR_KEEP_SELECTED: keep_sel_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign keep_selected = keep_sel_ff;

   // clamp the word size into one to the maximum
   always_comb begin
      if (word_bits_ff == '0) begin
         bits_clamped = BL_W'(1);
      end else if (int'(word_bits_ff) > MAX_WORD_BITS) begin
         bits_clamped = BL_W'(MAX_WORD_BITS);
      end else begin
         bits_clamped = BL_W'(word_bits_ff);
      end
   end

   assign masked_word = req_tx_word & data_mask_ff;

   // push accepted items into the queue
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !req_stall;
   assign q_entry   = {req_operation, req_din_level, bits_clamped,
                       MAX_WORD_BITS'(masked_word)};

endmodule

// ===== sv/smsb_queue.sv =====
// Short queue between front and back parts, register bank with pointers.
// Depends on smsb_pkg.
module smsb_queue #(
   parameter int ENTRY_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [ENTRY_W-1:0]         push_entry,
   input  logic                       pop,
   output logic [ENTRY_W-1:0]         head_entry,
   output smsb_pkg::queue_status_type status
);
   import smsb_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ENTRY_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head_entry   = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);

endmodule

// ===== sv/smsb_back.sv =====
// Back part: pin step sequencer, shift registers and the result register.
// Depends on smsb_pkg.
module smsb_back #(
   parameter int MAX_WORD_BITS = 32,
   parameter int ENTRY_W       = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  smsb_pkg::queue_status_type  q_status,
   input  logic [ENTRY_W-1:0]          q_entry,
   output logic                        q_pop,
   input  logic                        keep_selected,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_cs_level,
   output logic                        rsp_clk_level,
   output logic                        rsp_dout_level,
   output logic [smsb_pkg::WORD_W-1:0] rsp_rx_word,
   output logic                        rsp_word_done,
   output logic                        rsp_busy_res
);
   import smsb_pkg::*;

   localparam int BL_W  = $clog2(MAX_WORD_BITS + 1);
   localparam int IDX_W = (MAX_WORD_BITS > 1) ? $clog2(MAX_WORD_BITS) : 1;

   // unpacked queue entry
   logic                     e_op;
   logic                     e_din;
   logic [BL_W-1:0]          e_bits;
   logic [MAX_WORD_BITS-1:0] e_word;

   // sequencer state
   logic                     bus_sel_ff, bus_sel_in;
   logic [2:0]               phase_ff, phase_in;
   logic [BL_W-1:0]          bits_left_ff, bits_left_in;
   logic [MAX_WORD_BITS-1:0] send_ff, send_in;
   logic [MAX_WORD_BITS-1:0] recv_ff, recv_in;
   pins_type                 pins_ff, pins_in;
   logic                     done;
   logic [BL_W-1:0]          bits_dec;
   logic [IDX_W-1:0]         bit_idx;
   logic [63:0]              recv_wide;

   // result register
   logic                     out_valid_ff, out_valid_in;
   pins_type                 out_pins_ff;
   logic [WORD_W-1:0]        out_rx_ff;
   logic                     out_done_ff;
   logic                     out_busy_ff;

   assign {e_op, e_din, e_bits, e_word} = q_entry;

   // take the head item when the result register is free or being drained
   assign q_pop = q_status.valid && (!out_valid_ff || !rsp_stall);

   assign bits_dec = (bits_left_ff != '0) ? bits_left_ff - 1'b1 : bits_left_ff;
   assign bit_idx  = IDX_W'(bits_left_ff - 1'b1);

   // step the pin sequence
   always_comb begin
      bus_sel_in   = bus_sel_ff;
      phase_in     = phase_ff;
      bits_left_in = bits_left_ff;
      send_in      = send_ff;
      recv_in      = recv_ff;
      pins_in      = pins_ff;
      done         = 1'b0;
      if (e_op == OP_START) begin
         send_in      = e_word;
         recv_in      = '0;
         bits_left_in = e_bits;
         phase_in     = bus_sel_ff ? PH_BIT_DATA : PH_SELECT;
      end else begin
         case (phase_ff)
            PH_SELECT: begin
               pins_in    = '{cs: 1'b1, clk: 1'b0, dout: 1'b0};
               bus_sel_in = 1'b1;
               phase_in   = PH_SB_DATA;
            end
            PH_SB_DATA: begin
               pins_in.dout = 1'b1;
               phase_in     = PH_SB_CLKH;
            end
            PH_SB_CLKH: begin
               pins_in.clk = 1'b1;
               phase_in    = PH_SB_CLKL;
            end
            PH_SB_CLKL: begin
               pins_in.clk = 1'b0;
               phase_in    = PH_BIT_DATA;
            end
            PH_BIT_DATA: begin
               if (bits_left_ff == '0) begin
                  // release the bus
                  pins_in    = '0;
                  bus_sel_in = 1'b0;
                  phase_in   = PH_IDLE;
                  done       = 1'b1;
               end else begin
                  pins_in.dout = send_ff[bit_idx];
                  phase_in     = PH_BIT_CLKH;
               end
            end
            PH_BIT_CLKH: begin
               pins_in.clk = 1'b1;
               recv_in     = {recv_ff[MAX_WORD_BITS-2:0], e_din};
               phase_in    = PH_BIT_CLKL;
            end
            PH_BIT_CLKL: begin
               pins_in.clk  = 1'b0;
               bits_left_in = bits_dec;
               if (bits_dec != '0) begin
                  phase_in = PH_BIT_DATA;
               end else if (keep_selected) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  phase_in = PH_BIT_DATA;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_sel_ff   <= 1'b0;
         phase_ff     <= PH_IDLE;
         bits_left_ff <= '0;
         send_ff      <= '0;
         recv_ff      <= '0;
         pins_ff      <= '0;
      end else if (q_pop) begin
         bus_sel_ff   <= bus_sel_in;
         phase_ff     <= phase_in;
         bits_left_ff <= bits_left_in;
         send_ff      <= send_in;
         recv_ff      <= recv_in;
         pins_ff      <= pins_in;
      end
   end

   // hold the result until taken
   always_comb begin
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign recv_wide = 64'(recv_in);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_pins_ff <= pins_in;
         out_rx_ff   <= recv_wide[WORD_W-1:0];
         out_done_ff <= done;
         out_busy_ff <= (phase_in != PH_IDLE);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cs_level   = out_pins_ff.cs;
   assign rsp_clk_level  = out_pins_ff.clk;
   assign rsp_dout_level = out_pins_ff.dout;
   assign rsp_rx_word    = out_rx_ff;
   assign rsp_word_done  = out_done_ff;
   assign rsp_busy_res   = out_busy_ff;

endmodule

// ===== sv/spi_master_start_bit_shifter_unit.sv =====
// Top level of the SPI master start-bit shifter: front, queue and back parts.
// Depends on smsb_pkg, smsb_front, smsb_queue and smsb_back.
//
//   channel  direction  handshake         payload
//   req      in         valid / stall     operation, tx_word, din_level
//   rsp      out        valid / stall     cs, clk, dout levels, rx_word, word_done, busy_res
//   csr      in         valid / ready     index (2 bits), data (32 bits)
//
// One item per clock sustained while req_stall and rsp_stall stay low; each item gives one
// result, registered first in a queue slot and then in the result register in the back part.
// The back part steps one pin phase per item; the two-entry queue keeps
// acceptance going while a result waits under rsp_stall.
// Synchronous active-high reset empties the queue and returns the bus to idle,
// pins low, registers to word size 8, mask all ones, release after the word.
module spi_master_start_bit_shifter_unit #(
   parameter int MAX_WORD_BITS = smsb_pkg::MAX_WORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_operation,
   input  logic [smsb_pkg::WORD_W-1:0]      req_tx_word,
   input  logic                             req_din_level,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_cs_level,
   output logic                             rsp_clk_level,
   output logic                             rsp_dout_level,
   output logic [smsb_pkg::WORD_W-1:0]      rsp_rx_word,
   output logic                             rsp_word_done,
   output logic                             rsp_busy_res,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [smsb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [smsb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import smsb_pkg::*;

   localparam int BL_W    = $clog2(MAX_WORD_BITS + 1);
   localparam int ENTRY_W = 2 + BL_W + MAX_WORD_BITS;

   queue_status_type   q_status;
   logic               q_push;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_push_entry;
   logic [ENTRY_W-1:0] q_head_entry;
   logic               keep_selected;

   smsb_front #(
      .MAX_WORD_BITS(MAX_WORD_BITS),
      .ENTRY_W(ENTRY_W)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_tx_word(req_tx_word),
      .req_din_level(req_din_level),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .q_status(q_status),
      .q_push(q_push),
      .q_entry(q_push_entry),
      .keep_selected(keep_selected)
   );

   smsb_queue #(
      .ENTRY_W(ENTRY_W)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_entry(q_push_entry),
      .pop(q_pop),
      .head_entry(q_head_entry),
      .status(q_status)
   );

   smsb_back #(
      .MAX_WORD_BITS(MAX_WORD_BITS),
      .ENTRY_W(ENTRY_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_status(q_status),
      .q_entry(q_head_entry),
      .q_pop(q_pop),
      .keep_selected(keep_selected),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cs_level(rsp_cs_level),
      .rsp_clk_level(rsp_clk_level),
      .rsp_dout_level(rsp_dout_level),
      .rsp_rx_word(rsp_rx_word),
      .rsp_word_done(rsp_word_done),
      .rsp_busy_res(rsp_busy_res)
   );

endmodule
